[rtl/ipdfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipdfe_pkg;

    // Header byte count default and the widest supported header
    localparam int HEADER_LEN_DEF = 4;
    localparam int HEADER_LEN_MAX = 4;

    // Field widths
    localparam int DUR_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int HDR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [DUR_W-1:0] HEADER_MARK_RST  = 16'd3360;
    localparam logic [DUR_W-1:0] HEADER_SPACE_RST = 16'd1760;
    localparam logic [DUR_W-1:0] BIT_MARK_RST     = 16'd520;
    localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 16'd1370;
    localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = 16'd360;
    localparam logic [DUR_W-1:0] MESSAGE_GAP_RST  = 16'd32300;
    localparam logic [HDR_W-1:0] HEADER_BYTES_RST = 32'h0027_DA11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_MARK  = 3'd0,
        CFG_HEADER_SPACE = 3'd1,
        CFG_BIT_MARK     = 3'd2,
        CFG_ONE_SPACE    = 3'd3,
        CFG_ZERO_SPACE   = 3'd4,
        CFG_MESSAGE_GAP  = 3'd5,
        CFG_HEADER_BYTES = 3'd6
    } cfg_idx_t;

    // Register file contents as seen by the sequencer
    typedef struct packed {
        logic [DUR_W-1:0] header_mark_us;
        logic [DUR_W-1:0] header_space_us;
        logic [DUR_W-1:0] bit_mark_us;
        logic [DUR_W-1:0] one_space_us;
        logic [DUR_W-1:0] zero_space_us;
        logic [DUR_W-1:0] message_gap_us;
        logic [HDR_W-1:0] header_bytes;
    } cfg_t;

    // One mark/space pair
    typedef struct packed {
        logic             frame_end;
        logic             last_of_run;
        logic [DUR_W-1:0] space_us;
        logic [DUR_W-1:0] mark_us;
    } pair_t;

endpackage

`default_nettype wire

[rtl/ipdfe_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipdfe_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ipdfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ipdfe_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ipdfe_pkg::cfg_t                          cfg
);

    ipdfe_pkg::cfg_t cfg_reg;
    ipdfe_pkg::cfg_t cfg_next;
    logic            wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    // Register write decode; index seven is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (ipdfe_pkg::cfg_idx_t'(cfg_index))
                ipdfe_pkg::CFG_HEADER_MARK:
                    cfg_next.header_mark_us = cfg_data[ipdfe_pkg::DUR_W-1:0];
                ipdfe_pkg::CFG_HEADER_SPACE:
                    cfg_next.header_space_us = cfg_data[ipdfe_pkg::DUR_W-1:0];
                ipdfe_pkg::CFG_BIT_MARK:
                    cfg_next.bit_mark_us = cfg_data[ipdfe_pkg::DUR_W-1:0];
                ipdfe_pkg::CFG_ONE_SPACE:
                    cfg_next.one_space_us = cfg_data[ipdfe_pkg::DUR_W-1:0];
                ipdfe_pkg::CFG_ZERO_SPACE:
                    cfg_next.zero_space_us = cfg_data[ipdfe_pkg::DUR_W-1:0];
                ipdfe_pkg::CFG_MESSAGE_GAP:
                    cfg_next.message_gap_us = cfg_data[ipdfe_pkg::DUR_W-1:0];
                ipdfe_pkg::CFG_HEADER_BYTES:
                    cfg_next.header_bytes = cfg_data[ipdfe_pkg::HDR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark_us  <= ipdfe_pkg::HEADER_MARK_RST;
            cfg_reg.header_space_us <= ipdfe_pkg::HEADER_SPACE_RST;
            cfg_reg.bit_mark_us     <= ipdfe_pkg::BIT_MARK_RST;
            cfg_reg.one_space_us    <= ipdfe_pkg::ONE_SPACE_RST;
            cfg_reg.zero_space_us   <= ipdfe_pkg::ZERO_SPACE_RST;
            cfg_reg.message_gap_us  <= ipdfe_pkg::MESSAGE_GAP_RST;
            cfg_reg.header_bytes    <= ipdfe_pkg::HEADER_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ipdfe_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipdfe_seq #(
    parameter int HEADER_LEN = ipdfe_pkg::HEADER_LEN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ipdfe_pkg::cfg_t                   cfg,
    // byte from the input register
    input  wire logic                              byte_valid,
    input  wire logic [ipdfe_pkg::BYTE_W-1:0]      byte_data,
    input  wire logic                              byte_last,
    output logic                                   byte_take,
    // pair toward the output register
    input  wire logic                              pair_adv,
    output logic                                   pair_valid,
    output ipdfe_pkg::pair_t                       pair
);

    // Position map of one frame: header pair, header bits, data bits,
    // checksum bits, trailer pair
    localparam int DATA_POS_I = 1 + 8 * HEADER_LEN;
    localparam int CK_POS_I   = DATA_POS_I + 8;
    localparam int TR_POS_I   = CK_POS_I + 8;
    localparam int POS_W      = $clog2(TR_POS_I + 1);

    localparam logic [POS_W-1:0] DATA_POS = POS_W'(DATA_POS_I);
    localparam logic [POS_W-1:0] DATA_END = POS_W'(DATA_POS_I + 7);
    localparam logic [POS_W-1:0] CK_POS   = POS_W'(CK_POS_I);
    localparam logic [POS_W-1:0] TR_POS   = POS_W'(TR_POS_I);

    logic                          busy_reg, busy_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [ipdfe_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic                          last_reg, last_next;
    logic [ipdfe_pkg::BYTE_W-1:0]  sum_reg, sum_next;
    logic                          in_frame_reg, in_frame_next;

    logic [ipdfe_pkg::BYTE_W-1:0]  hdr_sum;
    logic [ipdfe_pkg::BYTE_W-1:0]  sum_base;
    logic [POS_W-1:0]              pos_end;
    logic [POS_W-1:0]              pos_m1;
    logic                          at_end;
    logic                          done;
    logic                          load;
    logic                          cur_bit;

    // Sum of the fixed header bytes
    always_comb
    begin
        hdr_sum = '0;
        for (int i = 0; i < HEADER_LEN; i++)
        begin
            hdr_sum = hdr_sum + cfg.header_bytes[8*i +: 8];
        end
    end

    assign sum_base   = in_frame_reg ? sum_reg : hdr_sum;
    assign pos_end    = last_reg ? TR_POS : DATA_END;
    assign at_end     = (pos_reg == pos_end);
    assign done       = busy_reg & pair_adv & at_end;
    assign load       = byte_valid & (~busy_reg | done);
    assign byte_take  = load;
    assign pair_valid = busy_reg;
    assign pos_m1     = pos_reg - 1'b1;

    // Bit being sent at the current position
    always_comb
    begin
        if (pos_reg < DATA_POS)
        begin
            cur_bit = cfg.header_bytes[pos_m1[4:0]];
        end
        else if (pos_reg < CK_POS)
        begin
            cur_bit = byte_reg[pos_m1[2:0]];
        end
        else
        begin
            cur_bit = sum_reg[pos_m1[2:0]];
        end
    end

    // Pair for the current position
    always_comb
    begin
        pair.last_of_run = at_end;
        pair.frame_end   = (pos_reg == TR_POS);
        if (pos_reg == '0)
        begin
            pair.mark_us  = cfg.header_mark_us;
            pair.space_us = cfg.header_space_us;
        end
        else if (pos_reg == TR_POS)
        begin
            pair.mark_us  = cfg.bit_mark_us;
            pair.space_us = cfg.message_gap_us;
        end
        else
        begin
            pair.mark_us  = cfg.bit_mark_us;
            pair.space_us = cur_bit ? cfg.one_space_us : cfg.zero_space_us;
        end
    end

    // Item load and position advance
    always_comb
    begin
        busy_next     = busy_reg;
        pos_next      = pos_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        sum_next      = sum_reg;
        in_frame_next = in_frame_reg;
        if (load)
        begin
            busy_next     = 1'b1;
            pos_next      = in_frame_reg ? DATA_POS : '0;
            byte_next     = byte_data;
            last_next     = byte_last;
            sum_next      = sum_base + byte_data;
            in_frame_next = ~byte_last;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg & pair_adv)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pos_reg      <= '0;
            last_reg     <= 1'b0;
            sum_reg      <= '0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pos_reg      <= pos_next;
            last_reg     <= last_next;
            sum_reg      <= sum_next;
            in_frame_reg <= in_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

[rtl/ir_pulse_distance_frame_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields (tdata / tuser from the low bit up)
// s_axis    in   tdata: data_byte[7:0]; tlast: final_byte
// m_axis    out  tdata: mark_us[15:0], space_us[31:16]; tlast: last_of_run;
//                tuser: frame_end
// cfg       in   cfg_index: register index 0..6; cfg_data: write value
//
// One mark/space pair leaves the output register per cycle unless m_axis stalls; that
// register sets the rate. A byte sends its data bits, with the header pair and header
// bits before them for the first byte of a frame and the checksum bits and trailer
// pair after them for the last. The next byte waits in the input register and starts
// with no gap. Reset is asynchronous and clears the open frame and the checksum. A
// stall on m_axis holds the pair; the input side fills and then stalls.

module ir_pulse_distance_frame_encoder_core #(
    parameter int HEADER_LEN = ipdfe_pkg::HEADER_LEN_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // data_byte[7:0]
    input  wire logic                               s_axis_tlast,   // final_byte
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [31:0]                             m_axis_tdata,   // mark_us, space_us
    output logic                                    m_axis_tlast,   // last_of_run
    output logic                                    m_axis_tuser,   // frame_end
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ipdfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ipdfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ipdfe_pkg::cfg_t   cfg;
    ipdfe_pkg::pair_t  pair;
    ipdfe_pkg::pair_t  out_pair_reg;
    logic              out_valid_reg, out_valid_next;
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              byte_take;
    logic              pair_valid;
    logic              pair_adv;
    logic              in_acc;

    ipdfe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipdfe_seq #(
        .HEADER_LEN (HEADER_LEN)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (in_valid_reg),
        .byte_data  (in_byte_reg),
        .byte_last  (in_last_reg),
        .byte_take  (byte_take),
        .pair_adv   (pair_adv),
        .pair_valid (pair_valid),
        .pair       (pair)
    );

    // Input register
    assign s_axis_tready = ~in_valid_reg;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_take)
        begin
            in_valid_next = 1'b0;
        end
        else if (in_acc)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Output register
    assign pair_adv       = ~out_valid_reg | m_axis_tready;
    assign out_valid_next = pair_adv ? pair_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_adv)
        begin
            out_pair_reg <= pair;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pair_reg.space_us, out_pair_reg.mark_us};
    assign m_axis_tlast  = out_pair_reg.last_of_run;
    assign m_axis_tuser  = out_pair_reg.frame_end;

endmodule

`default_nettype wire

[rtl/ipdfe_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipdfe_chk (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [31:0]                        m_axis_tdata,
    input wire logic                               m_axis_tlast,
    input wire logic                               m_axis_tuser
);

    // Trailer pair always closes the run of its byte
    a_trailer_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end pair without last_of_run");

    // An accepted byte still fills the input register in the cycle after its acceptance
    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accepting a byte");

    // Stalled output stays valid
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // Stalled output pair is held
    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output pair changed while stalled");

endmodule

bind ir_pulse_distance_frame_encoder_core ipdfe_chk u_ipdfe_chk (.*);

`default_nettype wire
